@@ design/u8dec_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants of the UTF-8 codepoint decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8dec_pkg;

	localparam int unsigned CP_W        = 21;
	localparam int unsigned OUT_DEPTH   = 4;

	localparam logic [CP_W-1:0] REPLACEMENT = 21'h00003F;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_CODE  = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	typedef struct packed {
		logic [CP_W-1:0] codepoint;
		logic            last_of_text;
	} cp_word_t;

endpackage

`default_nettype wire

@@ design/u8dec_byte_if.sv @@
// ----------------------------------------------------------------------------
// u8dec_byte_if
// Valid/ready channel carrying one text byte and its end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8dec_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

@@ design/u8dec_cp_if.sv @@
// ----------------------------------------------------------------------------
// u8dec_cp_if
// Valid/ready channel carrying one decoded codepoint and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8dec_cp_if
	import u8dec_pkg::*;
;
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] codepoint;
	logic            last_of_text;

	modport source (output valid, output codepoint, output last_of_text, input ready);
	modport sink   (input valid, input codepoint, input last_of_text, output ready);
endinterface

`default_nettype wire

@@ design/utf8_codepoint_decoder_top.sv @@
// ----------------------------------------------------------------------------
// utf8_codepoint_decoder_top
// Streaming UTF-8 decoder: one byte in, zero to two codepoints out.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                        | handshake
//  ---------+-----+--------------------------------+------------
//  text     | in  | text_byte[7:0], end_of_text    | valid/ready
//  points   | out | codepoint[20:0], last_of_text  | valid/ready
//
//  Takes one byte per cycle while text.ready is high, via the input register
//  into a DEPTH-entry (default OUT_DEPTH) queue that feeds the single output port.
//  A byte that interrupts a sequence adds a replacement word before its own.
//  text.ready drops only while a byte waits in the input register and the
//  queue cannot take two more words. Reset clears the decode state and queue.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_codepoint_decoder_top
	import u8dec_pkg::*;
#(
	parameter int unsigned DEPTH = OUT_DEPTH
) (
	input  wire         clk,
	input  wire         arst_n,
	u8dec_byte_if.sink  text,
	u8dec_cp_if.source  points
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            end_s1;

	logic [1:0]      rem_q;
	logic [CP_W-1:0] part_q;

	cp_word_t        fifo_q [DEPTH];
	logic [PW-1:0]   rd_q;
	logic [PW-1:0]   wr_q;
	logic [CW-1:0]   cnt_q;

	logic            room;
	logic            fire_s1;
	logic            take_in;
	logic            pop;

	logic            is_cont;
	logic [CP_W-1:0] cont_cp;
	logic [1:0]      cont_rem;
	logic [CP_W-1:0] lead_cp;
	logic [1:0]      lead_extra;
	logic            lead_done;

	logic [1:0]      rem_d;
	logic [CP_W-1:0] part_d;
	logic [1:0]      n_res;
	cp_word_t        res0;
	cp_word_t        res1;
	logic [PW-1:0]   wr_next;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign room    = (cnt_q <= CW'(DEPTH - 2));
	assign fire_s1 = valid_s1 && room;
	assign take_in = text.valid && text.ready;
	assign pop     = points.valid && points.ready;

	assign text.ready          = !valid_s1 || room;
	assign points.valid        = (cnt_q != '0);
	assign points.codepoint    = fifo_q[rd_q].codepoint;
	assign points.last_of_text = fifo_q[rd_q].last_of_text;

	assign is_cont  = ((byte_s1 & CONT_MASK) == CONT_CODE);
	assign cont_cp  = {part_q[CP_W-7:0], byte_s1[5:0]};
	assign cont_rem = rem_q - 2'd1;
	assign wr_next  = bump(wr_q);

	always_comb begin
		if (!byte_s1[7]) begin
			lead_cp    = CP_W'(byte_s1);
			lead_extra = 2'd0;
		end else if ((byte_s1 & LEAD2_MASK) == LEAD2_CODE) begin
			lead_cp    = CP_W'(byte_s1[4:0]);
			lead_extra = 2'd1;
		end else if ((byte_s1 & LEAD3_MASK) == LEAD3_CODE) begin
			lead_cp    = CP_W'(byte_s1[3:0]);
			lead_extra = 2'd2;
		end else if ((byte_s1 & LEAD4_MASK) == LEAD4_CODE) begin
			lead_cp    = CP_W'(byte_s1[2:0]);
			lead_extra = 2'd3;
		end else begin
			lead_cp    = REPLACEMENT;
			lead_extra = 2'd0;
		end
	end

	assign lead_done = (lead_extra == 2'd0) || end_s1;

	always_comb begin
		rem_d  = rem_q;
		part_d = part_q;
		n_res  = 2'd0;
		res0   = '0;
		res1   = '0;
		if ((rem_q != 2'd0) && is_cont) begin
			if ((cont_rem == 2'd0) || end_s1) begin
				res0   = '{codepoint: cont_cp, last_of_text: end_s1};
				n_res  = 2'd1;
				rem_d  = 2'd0;
				part_d = '0;
			end else begin
				rem_d  = cont_rem;
				part_d = cont_cp;
			end
		end else begin
			if (rem_q != 2'd0) begin
				res0  = '{codepoint: REPLACEMENT, last_of_text: 1'b0};
				res1  = '{codepoint: lead_cp, last_of_text: end_s1};
				n_res = lead_done ? 2'd2 : 2'd1;
			end else begin
				res0  = '{codepoint: lead_cp, last_of_text: end_s1};
				n_res = lead_done ? 2'd1 : 2'd0;
			end
			if (lead_done) begin
				rem_d  = 2'd0;
				part_d = '0;
			end else begin
				rem_d  = lead_extra;
				part_d = lead_cp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= text.text_byte;
			end_s1  <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= 2'd0;
			part_q <= '0;
		end else if (fire_s1) begin
			rem_q  <= rem_d;
			part_q <= part_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && (n_res != 2'd0)) begin
			fifo_q[wr_q] <= res0;
		end
		if (fire_s1 && (n_res == 2'd2)) begin
			fifo_q[wr_next] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (fire_s1) begin
				case (n_res)
					2'd1:    wr_q <= wr_next;
					2'd2:    wr_q <= bump(wr_next);
					default: wr_q <= wr_q;
				endcase
			end
			cnt_q <= cnt_q + (fire_s1 ? CW'(n_res) : CW'(0)) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

@@ design/u8dec_checker.sv @@
// ----------------------------------------------------------------------------
// u8dec_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u8dec_checker
	import u8dec_pkg::*;
(
	input wire            clk,
	input wire            arst_n,
	input wire            in_valid,
	input wire            in_ready,
	input wire            out_valid,
	input wire            out_ready,
	input wire [CP_W-1:0] out_codepoint,
	input wire            out_last
);

	wire in_accept = in_valid && in_ready;

	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_codepoint) && $stable(out_last))
		else $error("output word changed while stalled");

	a_stall_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no output word pending");

	a_result_from_byte: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_accept, 2))
		else $error("output word appeared without a byte two cycles earlier");

endmodule

bind utf8_codepoint_decoder_top u8dec_checker u_u8dec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (text.valid),
	.in_ready      (text.ready),
	.out_valid     (points.valid),
	.out_ready     (points.ready),
	.out_codepoint (points.codepoint),
	.out_last      (points.last_of_text)
);

`default_nettype wire
